/* rtl/pca_pkg.sv */
// Shared types, constants and CORDIC angle table for the pose compose accumulator.
// Used by the CORDIC unit and the top level.
`default_nettype none
package pca_pkg;
	localparam int CordicStepsDef = 14;
	localparam int AtanEntries = 20;
	localparam logic signed [15:0] PiQ13 = 16'sd25736;
	localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
	localparam logic signed [31:0] PiQ24 = 32'sd52707179;
	localparam logic signed [31:0] HalfPiQ24 = 32'sd26353589;
	localparam logic signed [33:0] InvGain = 34'sd652032874;
	localparam logic signed [15:0] OneQ14 = 16'sd16384;

	typedef enum logic [0:0] {
		CMD_LOAD = 1'b0,
		CMD_COMPOSE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_PREP,
		ST_BUILD,
		ST_TRANS,
		ST_ROT,
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] atan_q24(input logic [4:0] idx);
		case (idx)
			5'd0: atan_q24 = 32'sd13176795;
			5'd1: atan_q24 = 32'sd7778716;
			5'd2: atan_q24 = 32'sd4110060;
			5'd3: atan_q24 = 32'sd2086331;
			5'd4: atan_q24 = 32'sd1047214;
			5'd5: atan_q24 = 32'sd524117;
			5'd6: atan_q24 = 32'sd262123;
			5'd7: atan_q24 = 32'sd131069;
			5'd8: atan_q24 = 32'sd65536;
			5'd9: atan_q24 = 32'sd32768;
			5'd10: atan_q24 = 32'sd16384;
			5'd11: atan_q24 = 32'sd8192;
			5'd12: atan_q24 = 32'sd4096;
			5'd13: atan_q24 = 32'sd2048;
			5'd14: atan_q24 = 32'sd1024;
			5'd15: atan_q24 = 32'sd512;
			5'd16: atan_q24 = 32'sd256;
			5'd17: atan_q24 = 32'sd128;
			5'd18: atan_q24 = 32'sd64;
			5'd19: atan_q24 = 32'sd32;
			default: atan_q24 = 32'sd0;
		endcase
	endfunction
endpackage
`default_nettype wire

/* rtl/pca_cordic.sv */
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q3.13 angle in,
// Q.14 sine and cosine out. Depends on pca_pkg.
`default_nettype none
module pca_cordic #(
	parameter int CordicSteps = pca_pkg::CordicStepsDef
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire logic signed [15:0]  angle,
	output logic                     done,
	output logic signed [15:0]       sin_q14,
	output logic signed [15:0]       cos_q14
);
	import pca_pkg::*;

	localparam int Steps = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;

	logic signed [33:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic               neg_q, busy_q;
	logic [4:0]         step_q;
	logic signed [17:0] a_w;
	logic signed [31:0] z_w;
	logic signed [33:0] xs, ys, xf, yf, xr, yr;

	// Wrap the angle and scale it to Q.24; the fold into the right half plane happens at start
	always_comb begin
		a_w = 18'(angle);
		if (a_w >= 18'(PiQ13)) a_w = a_w - TwoPiQ13;
		if (a_w < -18'(PiQ13)) a_w = a_w + TwoPiQ13;
		z_w = 32'(a_w) <<< 11;
	end

	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;

	// Run micro-rotations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			neg_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				x_q <= InvGain;
				y_q <= '0;
				if (z_w > HalfPiQ24) begin
					z_q <= z_w - PiQ24; neg_q <= 1'b1;
				end else if (z_w < -HalfPiQ24) begin
					z_q <= z_w + PiQ24; neg_q <= 1'b1;
				end else begin
					z_q <= z_w; neg_q <= 1'b0;
				end
			end else if (busy_q) begin
				if (z_q >= 0) begin
					x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_q24(step_q);
				end else begin
					x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_q24(step_q);
				end
				step_q <= step_q + 5'd1;
				if (step_q == 5'(Steps - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Negate, round to Q.14 and clamp
	always_comb begin
		xf = neg_q ? -x_q : x_q;
		yf = neg_q ? -y_q : y_q;
		xr = (xf + 34'sd32768) >>> 16;
		yr = (yf + 34'sd32768) >>> 16;
		if (xr > 34'(OneQ14)) cos_q14 = OneQ14;
		else if (xr < -34'(OneQ14)) cos_q14 = -OneQ14;
		else cos_q14 = xr[15:0];
		if (yr > 34'(OneQ14)) sin_q14 = OneQ14;
		else if (yr < -34'(OneQ14)) sin_q14 = -OneQ14;
		else sin_q14 = yr[15:0];
	end

	cordic_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q < 5'(Steps)) else $error("cordic step overran");
	cordic_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	cordic_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("start lost");
endmodule
`default_nettype wire

/* rtl/pca_mac.sv */
// Shared multiply-accumulate unit: one 34x34 signed product per cycle into a
// 72-bit accumulator. Depends on nothing but the clock.
`default_nettype none
module pca_mac (
	input  wire                      clk,
	input  wire                      clr,
	input  wire                      en,
	input  wire logic signed [33:0]  a,
	input  wire logic signed [33:0]  b,
	output logic signed [71:0]       acc_q
);
	logic signed [67:0] prod_s1;
	logic               en_s1, clr_s1;

	// Register the product, then accumulate
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		en_s1 <= en;
		clr_s1 <= clr;
		if (clr_s1) acc_q <= en_s1 ? 72'(prod_s1) : '0;
		else if (en_s1) acc_q <= acc_q + 72'(prod_s1);
	end
endmodule
`default_nettype wire

/* rtl/pose_compose_accumulator.sv */
// Top level of the pose compose accumulator: sequencer, pose state and output register.
// Depends on pca_pkg, pca_cordic and pca_mac.
//
// channel  dir  payload (tdata from bit 0)
// s_axis   in   tdata: delta_x, delta_y, delta_z, delta_yaw, delta_pitch, delta_roll; tuser: command
// m_axis   out  tdata: pos_x, pos_y, pos_z, r00..r22
//
// One item runs three CORDIC rotations, the pitch products and the 9 matrix entries on
// the MAC, then for a compose 3 translation and 9 rotation sums, one after another on the
// single CORDIC unit and the single multiplier.
// Reset clears the pose to zero translation and identity rotation.
// s_axis_tready is low from acceptance until the result is taken on m_axis.
`default_nettype none
module pose_compose_accumulator #(
	parameter int CORDIC_STEPS = pca_pkg::CordicStepsDef
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [143:0] s_axis_tdata,  // delta_x, delta_y, delta_z, yaw, pitch, roll
	input  wire  [0:0]   s_axis_tuser,  // command
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [239:0] m_axis_tdata   // pos_x, pos_y, pos_z, r00..r22
);
	import pca_pkg::*;

	state_t state_q, state_d;
	logic signed [31:0] d_q [3];
	logic signed [15:0] ang_q [3];
	logic signed [15:0] sc_q [6];  // sy, cy, sp, cp, sr, cr
	logic signed [15:0] rd_q [9];
	logic signed [15:0] nr_q [9];
	logic signed [31:0] t_q [3];
	logic signed [15:0] r_q [9];
	logic signed [33:0] spsr_q, spcr_q;
	logic               cmd_q;
	logic [1:0]         ang_idx_q;
	logic [3:0]         ent_q;
	logic [2:0]         term_q;
	logic               cstart_q;
	logic               cdone;
	logic signed [15:0] csin, ccos;
	logic               mclr, men;
	logic signed [33:0] ma, mb;
	logic signed [71:0] macc;
	logic [1:0]         ri, ci;
	logic signed [15:0] sy, cy, sp, cp, sr, cr;
	logic signed [71:0] rnd_w;
	logic signed [15:0] sat16_w;
	logic signed [71:0] tsum_w;
	logic signed [31:0] sat32_w;

	pca_cordic #(.CordicSteps(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .start(cstart_q), .angle(ang_q[ang_idx_q]),
		.done(cdone), .sin_q14(csin), .cos_q14(ccos)
	);

	pca_mac u_mac (.clk, .clr(mclr), .en(men), .a(ma), .b(mb), .acc_q(macc));

	assign sy = sc_q[0]; assign cy = sc_q[1]; assign sp = sc_q[2];
	assign cp = sc_q[3]; assign sr = sc_q[4]; assign cr = sc_q[5];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign ri = (ent_q >= 4'd6) ? 2'd2 : (ent_q >= 4'd3) ? 2'd1 : 2'd0;
	assign ci = 2'(ent_q - 4'(ri) * 4'd3);

	// Select MAC operands: terms 0, 0..1 or 0..2 feed the product, terms 3 and 4 let the
	// product pipeline drain, term 4 rounds
	always_comb begin
		ma = '0; mb = '0; men = 1'b0;
		mclr = (term_q == 3'd0) || (state_q == ST_PREP);
		if (term_q < 3'd3) begin
			case (state_q)
				ST_PREP: begin
					case (term_q)
						3'd0: begin men = 1'b1; ma = 34'(sp); mb = 34'(sr); end
						3'd1: begin men = 1'b1; ma = 34'(sp); mb = 34'(cr); end
						default: men = 1'b0;
					endcase
				end
				ST_BUILD: begin
					men = 1'b1;
					case (ent_q)
						4'd0: if (term_q == 0) begin ma = 34'(cy) * 34'sd1; mb = 34'(cp) <<< 14; end
						      else men = 1'b0;
						4'd1: if (term_q == 0) begin ma = 34'(cy); mb = spsr_q; end
						      else if (term_q == 1) begin ma = -34'(sy); mb = 34'(cr) <<< 14; end
						      else men = 1'b0;
						4'd2: if (term_q == 0) begin ma = 34'(cy); mb = spcr_q; end
						      else if (term_q == 1) begin ma = 34'(sy); mb = 34'(sr) <<< 14; end
						      else men = 1'b0;
						4'd3: if (term_q == 0) begin ma = 34'(sy); mb = 34'(cp) <<< 14; end
						      else men = 1'b0;
						4'd4: if (term_q == 0) begin ma = 34'(sy); mb = spsr_q; end
						      else if (term_q == 1) begin ma = 34'(cy); mb = 34'(cr) <<< 14; end
						      else men = 1'b0;
						4'd5: if (term_q == 0) begin ma = 34'(sy); mb = spcr_q; end
						      else if (term_q == 1) begin ma = -34'(cy); mb = 34'(sr) <<< 14; end
						      else men = 1'b0;
						4'd6: if (term_q == 0) begin ma = -34'(sp); mb = 34'sd268435456; end
						      else men = 1'b0;
						4'd7: if (term_q == 0) begin ma = 34'(cp); mb = 34'(sr) <<< 14; end
						      else men = 1'b0;
						4'd8: if (term_q == 0) begin ma = 34'(cp); mb = 34'(cr) <<< 14; end
						      else men = 1'b0;
						default: men = 1'b0;
					endcase
				end
				ST_TRANS: begin
					men = 1'b1;
					ma = 34'(r_q[ent_q * 4'd3 + 4'(term_q)]);
					mb = 34'(d_q[term_q[1:0]]);
				end
				ST_ROT: begin
					men = 1'b1;
					ma = 34'(r_q[4'(ri) * 4'd3 + 4'(term_q)]);
					mb = 34'(rd_q[4'(term_q) * 4'd3 + 4'(ci)]);
				end
				default: men = 1'b0;
			endcase
		end
	end

	// Rounding and saturation of the finished sum, and its addition to the translation
	always_comb begin
		if (state_q == ST_BUILD) rnd_w = (macc + 72'sd134217728) >>> 28;
		else rnd_w = (macc + 72'sd8192) >>> 14;
		if (rnd_w > 72'sd32767) sat16_w = 16'sh7fff;
		else if (rnd_w < -72'sd32768) sat16_w = -16'sh8000;
		else sat16_w = rnd_w[15:0];
		tsum_w = 72'(t_q[ent_q[1:0]]) + rnd_w;
		if (tsum_w > 72'sd2147483647) sat32_w = 32'sh7fffffff;
		else if (tsum_w < -72'sd2147483648) sat32_w = -32'sh80000000;
		else sat32_w = tsum_w[31:0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_CORDIC;
			ST_CORDIC: if (cdone && ang_idx_q == 2'd2) state_d = ST_PREP;
			ST_PREP: if (term_q == 3'd3) state_d = ST_BUILD;
			ST_BUILD: if (term_q == 3'd4 && ent_q == 4'd8)
				state_d = (cmd_q == CMD_COMPOSE) ? ST_TRANS : ST_OUT;
			ST_TRANS: if (term_q == 3'd4 && ent_q == 4'd2) state_d = ST_ROT;
			ST_ROT: if (term_q == 3'd4 && ent_q == 4'd8) state_d = ST_OUT;
			ST_OUT: if (m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Sequence counters and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cstart_q <= 1'b0;
			ang_idx_q <= '0;
			ent_q <= '0;
			term_q <= '0;
			for (int i = 0; i < 3; i++) t_q[i] <= '0;
			for (int i = 0; i < 9; i++) r_q[i] <= (i % 4 == 0) ? OneQ14 : 16'sd0;
			for (int i = 0; i < 3; i++) d_q[i] <= '0;
			for (int i = 0; i < 3; i++) ang_q[i] <= '0;
			for (int i = 0; i < 6; i++) sc_q[i] <= '0;
			for (int i = 0; i < 9; i++) rd_q[i] <= '0;
			for (int i = 0; i < 9; i++) nr_q[i] <= '0;
			spsr_q <= '0;
			spcr_q <= '0;
			cmd_q <= 1'b0;
		end else begin
			cstart_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					d_q[0] <= s_axis_tdata[31:0];
					d_q[1] <= s_axis_tdata[63:32];
					d_q[2] <= s_axis_tdata[95:64];
					ang_q[0] <= s_axis_tdata[111:96];
					ang_q[1] <= s_axis_tdata[127:112];
					ang_q[2] <= s_axis_tdata[143:128];
					cmd_q <= s_axis_tuser[0];
					ang_idx_q <= '0;
					cstart_q <= 1'b1;
				end
				ST_CORDIC: if (cdone) begin
					sc_q[{ang_idx_q, 1'b0}] <= csin;
					sc_q[{ang_idx_q, 1'b1}] <= ccos;
					ent_q <= '0; term_q <= '0;
					if (ang_idx_q != 2'd2) begin
						ang_idx_q <= ang_idx_q + 2'd1;
						cstart_q <= 1'b1;
					end
				end
				// Capture the pitch products sp*sr and sp*cr as they leave the MAC
				ST_PREP: begin
					if (term_q == 3'd2) spsr_q <= macc[33:0];
					if (term_q == 3'd3) begin
						spcr_q <= macc[33:0];
						term_q <= '0;
						ent_q <= '0;
					end else begin
						term_q <= term_q + 3'd1;
					end
				end
				ST_BUILD, ST_TRANS, ST_ROT: begin
					if (term_q == 3'd4) begin
						term_q <= '0;
						if (state_q == ST_BUILD) rd_q[ent_q] <= sat16_w;
						else if (state_q == ST_TRANS) t_q[ent_q[1:0]] <= sat32_w;
						else nr_q[ent_q] <= sat16_w;
						if (state_q == state_d) ent_q <= ent_q + 4'd1;
						else ent_q <= '0;
						if (state_q == ST_BUILD && state_d == ST_OUT) begin
							for (int i = 0; i < 9; i++) r_q[i] <= (i == 8) ? sat16_w : rd_q[i];
							for (int i = 0; i < 3; i++) t_q[i] <= d_q[i];
						end
						if (state_q == ST_ROT && state_d == ST_OUT) begin
							for (int i = 0; i < 9; i++) r_q[i] <= (i == 8) ? sat16_w : nr_q[i];
						end
					end else begin
						term_q <= term_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Result register
	assign m_axis_tvalid = (state_q == ST_OUT);
	always_comb begin
		m_axis_tdata[31:0] = t_q[0];
		m_axis_tdata[63:32] = t_q[1];
		m_axis_tdata[95:64] = t_q[2];
		for (int i = 0; i < 9; i++) m_axis_tdata[96 + 16 * i +: 16] = r_q[i];
	end

	pca_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
	pca_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("took two items");
	pca_term_bound: assert property (@(posedge clk) disable iff (!arst_n)
		term_q <= 3'd4) else $error("term overran");
	pca_ent_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ent_q <= 4'd8) else $error("entry overran");
endmodule
`default_nettype wire
